/* design/cst_pkg.sv */
// Shared types and constants for the client session table.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps

package cst_pkg;

    localparam int SLOTS_DEFAULT  = 8;
    localparam int SLOTS_MAX      = 64;
    localparam logic [15:0] TIMEOUT_RESET = 16'd300;

    // Widths of the stream payloads.
    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 3;

    // Operation codes carried on the input tuser.
    localparam logic [1:0] OP_JOIN  = 2'd0;
    localparam logic [1:0] OP_LEAVE = 2'd1;
    localparam logic [1:0] OP_INPUT = 2'd2;
    localparam logic [1:0] OP_TICK  = 2'd3;

    // Result status codes carried on the output tuser.
    localparam logic [2:0] ST_JOINED         = 3'd0;
    localparam logic [2:0] ST_FULL           = 3'd1;
    localparam logic [2:0] ST_LEFT           = 3'd2;
    localparam logic [2:0] ST_LEAVE_REJECTED = 3'd3;
    localparam logic [2:0] ST_INPUT_TAKEN    = 3'd4;
    localparam logic [2:0] ST_INPUT_DISCARD  = 3'd5;
    localparam logic [2:0] ST_SLOT_REPORT    = 3'd6;
    localparam logic [2:0] ST_NONE_ACTIVE    = 3'd7;

    localparam logic [15:0] IDLE_MAX = 16'hFFFF;

    // Action that the datapath performs while it loads a result.
    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_JOIN  = 3'd1,
        ACT_FULL  = 3'd2,
        ACT_LEAVE = 3'd3,
        ACT_INPUT = 3'd4,
        ACT_TICK  = 3'd5,
        ACT_EMPTY = 3'd6
    } act_t;

    // One stored session.
    typedef struct packed {
        logic [31:0] address;
        logic [15:0] port;
        logic [3:0]  keys;
        logic [15:0] idle;
    } slot_rec_t;

    // Controller to datapath.
    typedef struct packed {
        logic load_item;
        logic idx_clear;
        logic idx_inc;
        logic rd_en;
        logic rd_by_slot;
        act_t act;
    } cst_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic [1:0] new_op;
        logic [1:0] item_op;
        logic       idx_used;
        logic       idx_last;
        logic       slot_in_range;
        logic       more_above;
        logic       out_free;
    } cst_status_t;

endpackage

/* design/cst_ctrl.sv */
// Sequencing state machine of the client session table.
// Depends on cst_pkg for the command and status structs.
`timescale 1ns / 1ps

module cst_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  cst_pkg::cst_status_t stat,
    output cst_pkg::cst_cmd_t    cmd
);

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_JOIN_SCAN = 6'b000010,
        S_LOOKUP    = 6'b000100,
        S_MATCH     = 6'b001000,
        S_TICK_SCAN = 6'b010000,
        S_TICK_EVAL = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        cmd.load_item  = 1'b0;
        cmd.idx_clear  = 1'b0;
        cmd.idx_inc    = 1'b0;
        cmd.rd_en      = 1'b0;
        cmd.rd_by_slot = 1'b0;
        cmd.act        = cst_pkg::ACT_NONE;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    cmd.idx_clear = 1'b1;
                    unique case (stat.new_op) inside
                        cst_pkg::OP_JOIN:  state_next = S_JOIN_SCAN;
                        cst_pkg::OP_LEAVE,
                        cst_pkg::OP_INPUT: state_next = S_LOOKUP;
                        default:           state_next = S_TICK_SCAN;
                    endcase
                end
            end

            S_JOIN_SCAN:
            begin
                if (!stat.idx_used)
                begin
                    if (stat.out_free)
                    begin
                        cmd.act    = cst_pkg::ACT_JOIN;
                        state_next = S_IDLE;
                    end
                end
                else if (stat.idx_last)
                begin
                    if (stat.out_free)
                    begin
                        cmd.act    = cst_pkg::ACT_FULL;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end

            S_LOOKUP:
            begin
                cmd.rd_en      = stat.slot_in_range;
                cmd.rd_by_slot = 1'b1;
                state_next     = S_MATCH;
            end

            S_MATCH:
            begin
                if (stat.out_free)
                begin
                    cmd.act    = (stat.item_op == cst_pkg::OP_LEAVE) ?
                                 cst_pkg::ACT_LEAVE : cst_pkg::ACT_INPUT;
                    state_next = S_IDLE;
                end
            end

            S_TICK_SCAN:
            begin
                if (stat.idx_used)
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_TICK_EVAL;
                end
                else if (stat.idx_last)
                begin
                    // Only reached when no slot was in use at all.
                    if (stat.out_free)
                    begin
                        cmd.act    = cst_pkg::ACT_EMPTY;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end

            S_TICK_EVAL:
            begin
                if (stat.out_free)
                begin
                    cmd.act = cst_pkg::ACT_TICK;
                    if (stat.more_above)
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_TICK_SCAN;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* design/cst_datapath.sv */
// Session storage, scan index, timeout register and result register.
// Depends on cst_pkg; driven by cst_ctrl through the command struct.
`timescale 1ns / 1ps

module cst_datapath
#(
    parameter int SLOTS = cst_pkg::SLOTS_DEFAULT
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [cst_pkg::S_TDATA_W-1:0]   in_data,
    input  logic [cst_pkg::S_TUSER_W-1:0]   in_user,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [cst_pkg::M_TDATA_W-1:0]   out_data,
    output logic [cst_pkg::M_TUSER_W-1:0]   out_user,
    output logic                            out_last,
    input  logic                            cfg_write_en,
    input  logic [15:0]                     cfg_write_data,
    input  cst_pkg::cst_cmd_t               cmd,
    output cst_pkg::cst_status_t            stat
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Latched input item.
    logic [1:0]  op_reg;
    logic [31:0] addr_reg;
    logic [15:0] port_reg;
    logic [15:0] slot_reg;
    logic [3:0]  keys_reg;

    logic [SLOT_W-1:0] idx_reg;
    logic [SLOT_W-1:0] idx_next;
    logic [SLOTS-1:0]  used_reg;
    logic [SLOTS-1:0]  used_next;
    logic [15:0]       timeout_reg;

    cst_pkg::slot_rec_t mem [SLOTS];
    cst_pkg::slot_rec_t rd_data_reg;
    cst_pkg::slot_rec_t wr_data;
    logic               wr_en;
    logic [SLOT_W-1:0]  wr_addr;
    logic [SLOT_W-1:0]  rd_addr;

    logic              out_valid_reg;
    logic [2:0]        status_reg;
    logic [5:0]        index_reg;
    logic [3:0]        held_reg;
    logic              tmo_reg;
    logic              last_reg;

    logic [SLOT_W-1:0] slot_lo;
    logic              in_range;
    logic              ep_match;
    logic [SLOTS-1:0]  above;
    logic [15:0]       idle_inc;
    logic              tmo;
    logic              out_free;
    logic [5:0]        shown;

    assign slot_lo  = slot_reg[SLOT_W-1:0];
    assign in_range = slot_reg < 16'(SLOTS);
    assign ep_match = in_range && used_reg[slot_lo] &&
                      rd_data_reg.address == addr_reg && rd_data_reg.port == port_reg;
    assign above    = (used_reg >> idx_reg) >> 1;
    assign idle_inc = (rd_data_reg.idle == cst_pkg::IDLE_MAX) ?
                      rd_data_reg.idle : rd_data_reg.idle + 16'd1;
    assign tmo      = idle_inc > timeout_reg;
    assign out_free = !out_valid_reg || out_ready;
    assign shown    = in_range ? 6'(slot_reg) : 6'd0;

    assign stat.new_op        = in_user;
    assign stat.item_op       = op_reg;
    assign stat.idx_used      = used_reg[idx_reg];
    assign stat.idx_last      = idx_reg == SLOT_W'(SLOTS - 1);
    assign stat.slot_in_range = in_range;
    assign stat.more_above    = |above;
    assign stat.out_free      = out_free;

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg   <= in_user;
            addr_reg <= in_data[31:0];
            port_reg <= in_data[47:32];
            slot_reg <= in_data[63:48];
            keys_reg <= in_data[67:64];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= cst_pkg::TIMEOUT_RESET;
        end
        else if (cfg_write_en)
        begin
            timeout_reg <= cfg_write_data;
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_clear)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + SLOT_W'(1);
        end
    end

    // Memory write port and valid-bit update.
    always_comb
    begin
        used_next = used_reg;
        wr_en     = 1'b0;
        wr_addr   = idx_reg;
        wr_data   = rd_data_reg;
        case (cmd.act)
            cst_pkg::ACT_JOIN:
            begin
                wr_en              = 1'b1;
                wr_data.address    = addr_reg;
                wr_data.port       = port_reg;
                wr_data.keys       = '0;
                wr_data.idle       = '0;
                used_next[idx_reg] = 1'b1;
            end
            cst_pkg::ACT_LEAVE:
            begin
                if (ep_match)
                begin
                    used_next[slot_lo] = 1'b0;
                end
            end
            cst_pkg::ACT_INPUT:
            begin
                wr_en        = ep_match;
                wr_addr      = slot_lo;
                wr_data.keys = keys_reg;
                wr_data.idle = '0;
            end
            cst_pkg::ACT_TICK:
            begin
                wr_en        = 1'b1;
                wr_data.idle = idle_inc;
                if (tmo)
                begin
                    used_next[idx_reg] = 1'b0;
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    assign rd_addr = cmd.rd_by_slot ? slot_lo : idx_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            used_reg <= '0;
        end
        else
        begin
            idx_reg  <= idx_next;
            used_reg <= used_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.act != cst_pkg::ACT_NONE)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.act != cst_pkg::ACT_NONE)
        begin
            index_reg <= '0;
            held_reg  <= '0;
            tmo_reg   <= 1'b0;
            last_reg  <= 1'b1;
            case (cmd.act)
                cst_pkg::ACT_JOIN:
                begin
                    status_reg <= cst_pkg::ST_JOINED;
                    index_reg  <= 6'(idx_reg);
                end
                cst_pkg::ACT_FULL:
                begin
                    status_reg <= cst_pkg::ST_FULL;
                end
                cst_pkg::ACT_LEAVE:
                begin
                    status_reg <= ep_match ? cst_pkg::ST_LEFT : cst_pkg::ST_LEAVE_REJECTED;
                    index_reg  <= shown;
                end
                cst_pkg::ACT_INPUT:
                begin
                    status_reg <= ep_match ? cst_pkg::ST_INPUT_TAKEN :
                                             cst_pkg::ST_INPUT_DISCARD;
                    index_reg  <= shown;
                    held_reg   <= ep_match ? keys_reg : 4'd0;
                end
                cst_pkg::ACT_TICK:
                begin
                    status_reg <= cst_pkg::ST_SLOT_REPORT;
                    index_reg  <= 6'(idx_reg);
                    held_reg   <= rd_data_reg.keys;
                    tmo_reg    <= tmo;
                    last_reg   <= !(|above);
                end
                default:
                begin
                    status_reg <= cst_pkg::ST_NONE_ACTIVE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_user  = status_reg;
    assign out_last  = last_reg;
    assign out_data  = {5'd0, tmo_reg, held_reg, index_reg};

endmodule

/* design/client_session_table.sv */
// Top level of the client session table: controller plus datapath.
// Depends on cst_pkg, cst_ctrl and cst_datapath.
//
//  channel  | direction | transfer contents
//  ---------+-----------+----------------------------------------------------------
//  s_*      | in        | tuser op; tdata address, port, slot number, key bits
//  m_*      | out       | tuser status; tdata slot index, held keys, timed out; tlast
//  cfg_*    | in        | timeout_ticks write, one register, no read-back
//
// One item at a time; a leave or key input reads the addressed slot, then loads its result;
// a join scans up from slot zero to the first free slot, or reports full when there is none.
// A tick scans up from slot zero; for each occupied slot it reads the memory, then writes back
// the idle count with a slot report; with no slot in use it gives one none-active result.
// Reset clears the valid bits and loads timeout_ticks with 300; the session memory is not
// cleared since a join writes the whole entry. A stalled result holds the scan in place.
`timescale 1ns / 1ps

module client_session_table
#(
    parameter int SLOTS = cst_pkg::SLOTS_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // Input stream.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [31:0] peer_address, [47:32] peer_port, [63:48] slot_number, [67:64] key_bits
    input  logic [cst_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] op
    input  logic [cst_pkg::S_TUSER_W-1:0] s_tuser,
    // Result stream.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [5:0] slot_index, [9:6] held_keys, [10] timed_out
    output logic [cst_pkg::M_TDATA_W-1:0] m_tdata,
    // [2:0] status
    output logic [cst_pkg::M_TUSER_W-1:0] m_tuser,
    // last_result
    output logic                          m_tlast,
    // Configuration: timeout_ticks.
    input  logic                          cfg_write_en,
    input  logic [15:0]                   cfg_write_data
);

    cst_pkg::cst_cmd_t    cmd;
    cst_pkg::cst_status_t stat;

    // The controller owns the handshake on the input side and decides when
    // the datapath scans, reads the session memory and loads a result.
    cst_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the sessions, the valid bits and the result register.
    cst_datapath
    #(
        .SLOTS (SLOTS)
    )
    u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_data        (s_tdata),
        .in_user        (s_tuser),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_data       (m_tdata),
        .out_user       (m_tuser),
        .out_last       (m_tlast),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .cmd            (cmd),
        .stat           (stat)
    );

endmodule

/* design/cst_checker.sv */
// Port-level checks for the client session table, bound to the top level.
// Depends on cst_pkg and client_session_table.
`timescale 1ns / 1ps

module cst_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [cst_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [cst_pkg::M_TUSER_W-1:0] m_tuser,
    input logic                          m_tlast
);

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // The block is busy after taking an item, so items are never accepted back to back.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted back to back");

    // Only slot reports can be followed by further results of the same item.
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != cst_pkg::ST_SLOT_REPORT |-> m_tlast)
        else $error("single result without last");

    // A timeout flag appears only on a slot report.
    a_tmo_report: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[10] |-> m_tuser == cst_pkg::ST_SLOT_REPORT)
        else $error("timeout flag outside a report");

    // A full table reports slot zero.
    a_full_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == cst_pkg::ST_FULL |-> m_tdata[5:0] == 6'd0)
        else $error("full result with nonzero index");

endmodule

bind client_session_table cst_checker u_cst_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
